// ===== design/stream_find_and_replace_top_assert.svh =====
// Assertion macros shared by the find-and-replace checker.
// Depends on nothing; included by the checker file.
`ifndef STREAM_FIND_AND_REPLACE_TOP_ASSERT_SVH
`define STREAM_FIND_AND_REPLACE_TOP_ASSERT_SVH

// A condition that holds whenever the block is out of reset.
`define SFR_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// An implication checked in the same cycle.
`define SFR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// An implication checked in the next cycle.
`define SFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/sfr_pkg.sv =====
// Shared constants, types and helper functions of the stream find-and-replace block.
// Depends on nothing; used by every module of the block.
package sfr_pkg;

    localparam int MAX_FIND_LEN    = 8;
    localparam int MAX_REPLACE_LEN = 8;
    localparam int BYTE_W          = 8;
    localparam int LEN_W           = 4;
    localparam int PAT_W           = 64;
    localparam int DATA_W          = 64;
    localparam int ADDR_W          = 5;
    localparam int IDX_LSB         = 3;
    localparam int IDX_W           = ADDR_W - IDX_LSB;

    // Window occupancy counts 0..MAX_FIND_LEN.
    localparam int CNT_W = $clog2(MAX_FIND_LEN + 1);

    // The emit chain holds the most results a single byte can cause.
    localparam int EMIT_DEPTH = (MAX_FIND_LEN > MAX_REPLACE_LEN) ? MAX_FIND_LEN
                                                                 : MAX_REPLACE_LEN;
    localparam int EMIT_W     = $clog2(EMIT_DEPTH + 1);

    // Register map, one 64-bit register every 8 bytes.
    typedef enum logic [IDX_W-1:0] {
        REG_FIND_PAT = 2'd0,
        REG_FIND_LEN = 2'd1,
        REG_REPL_PAT = 2'd2,
        REG_REPL_LEN = 2'd3
    } t_reg_idx;

    // One result item as it travels through the emit chain.
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
        logic              has;
        logic              run_last;
        logic              str_end;
    } t_res;

    // Find length as used: zero reads as one, oversized values saturate.
    function automatic logic [CNT_W-1:0] eff_find_len(input logic [LEN_W-1:0] len);
        logic [CNT_W-1:0] res;
        if (len == '0) begin
            res = CNT_W'(1);
        end else if (int'(len) > MAX_FIND_LEN) begin
            res = CNT_W'(MAX_FIND_LEN);
        end else begin
            res = CNT_W'(len);
        end
        return res;
    endfunction

    // Replace length as used: oversized values saturate.
    function automatic logic [EMIT_W-1:0] eff_repl_len(input logic [LEN_W-1:0] len);
        logic [EMIT_W-1:0] res;
        if (int'(len) > MAX_REPLACE_LEN) begin
            res = EMIT_W'(MAX_REPLACE_LEN);
        end else begin
            res = EMIT_W'(len);
        end
        return res;
    endfunction

endpackage

// ===== design/sfr_win_cell.sv =====
// One cell of the pending-byte window: holds a byte, compares it with its pattern byte.
// Depends on sfr_pkg.
module sfr_win_cell (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic                      i_take_in,
    input  logic                      i_shift,
    input  logic [sfr_pkg::BYTE_W-1:0] i_in_byte,
    input  logic [sfr_pkg::BYTE_W-1:0] i_pat_byte,
    input  logic [sfr_pkg::BYTE_W-1:0] i_next_cand,
    output logic [sfr_pkg::BYTE_W-1:0] o_cand,
    output logic                      o_eq
);

    logic [sfr_pkg::BYTE_W-1:0] r_byte;
    logic [sfr_pkg::BYTE_W-1:0] n_byte;

    // The window content with the incoming byte dropped into the free slot.
    assign o_cand = i_take_in ? i_in_byte : r_byte;
    assign o_eq   = (o_cand == i_pat_byte);

    // On a miss the window moves one place toward the oldest end.
    assign n_byte = i_shift ? i_next_cand : o_cand;

    // Window bytes need no reset; only slots below the count are ever read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_byte <= n_byte;
        end
    end

endmodule

// ===== design/sfr_emit_cell.sv =====
// One cell of the emit chain: holds a result and passes it toward the output head.
// Depends on sfr_pkg.
module sfr_emit_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  logic          i_shift,
    input  sfr_pkg::t_res i_load_res,
    input  sfr_pkg::t_res i_next_res,
    output sfr_pkg::t_res o_res
);

    logic          r_valid;
    sfr_pkg::t_res r_res;
    sfr_pkg::t_res n_res;

    // A new burst loads the whole chain; otherwise the chain moves when the head leaves.
    // When the cell holds, its valid flag comes from the reset register.
    always_comb begin
        n_res       = r_res;
        n_res.valid = r_valid;
        if (i_load) begin
            n_res = i_load_res;
        end else if (i_shift) begin
            n_res = i_next_res;
        end
    end

    // The valid flag is control state and is reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_res.valid;
        end
    end

    // The payload carries no reset.
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    always_comb begin
        o_res       = r_res;
        o_res.valid = r_valid;
    end

endmodule

// ===== design/stream_find_and_replace_top.sv =====
// Top level of the streaming find-and-replace block.
// Depends on sfr_pkg, sfr_win_cell and sfr_emit_cell.
//
// Usage: source bytes enter on the input channel (i_in_valid/o_in_ready, i_in_byte,
// i_in_last marks the final byte of a string). Output bytes leave on the output
// channel (o_out_valid/i_out_ready) with o_has_byte, o_run_last and o_string_end.
// The search and replacement strings and their lengths are written over the APB
// port while no string is in flight; writing the find length empties the window.
// The results of a byte are loaded into the emit chain when the byte is transferred
// and leave through the output register. Throughput: one byte per cycle while each
// byte causes at most one result and results are taken. A byte causing more sends
// them one per cycle while taken, stalling the input until the emit chain drains.
// The window is a row of cells compared in parallel, and the results of one byte
// are loaded into a second row of cells that shifts them out through an output
// register. A new byte is taken as soon as the emit chain drains, even while the
// output register is held by a stalled receiver.
// Reset empties the window, the emit chain and the output register, and loads the
// register reset values (find length one, replace length zero, zero patterns).
module stream_find_and_replace_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Source byte channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [sfr_pkg::BYTE_W-1:0]      i_in_byte,
    input  logic                            i_in_last,
    // Result channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [sfr_pkg::BYTE_W-1:0]      o_out_byte,
    output logic                            o_has_byte,
    output logic                            o_run_last,
    output logic                            o_string_end,
    // Configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sfr_pkg::ADDR_W-1:0]      paddr,
    input  logic [sfr_pkg::DATA_W-1:0]      pwdata,
    output logic [sfr_pkg::DATA_W-1:0]      prdata,
    output logic                            pready
);

    localparam int NW = sfr_pkg::MAX_FIND_LEN;
    localparam int NE = sfr_pkg::EMIT_DEPTH;
    localparam int BW = sfr_pkg::BYTE_W;

    // Configuration registers
    logic [sfr_pkg::PAT_W-1:0] r_find_pat;
    logic [sfr_pkg::LEN_W-1:0] r_find_len;
    logic [sfr_pkg::PAT_W-1:0] r_repl_pat;
    logic [sfr_pkg::LEN_W-1:0] r_repl_len;
    logic                      cfg_wr;
    sfr_pkg::t_reg_idx         cfg_idx;

    // Window control
    logic [sfr_pkg::CNT_W-1:0] r_cnt;
    logic [sfr_pkg::CNT_W-1:0] n_cnt;
    logic [sfr_pkg::CNT_W-1:0] new_cnt;
    logic [sfr_pkg::CNT_W-1:0] flen;
    logic [sfr_pkg::EMIT_W-1:0] rlen;
    logic                      accept;
    logic                      full;
    logic                      hit;
    logic                      shift_win;
    logic                      marker;
    logic [NW-1:0]             eq;
    logic [NW-1:0]             cmp_en;
    logic [BW-1:0]             cand [NW];

    // Emit chain
    logic [sfr_pkg::EMIT_W-1:0] num_res;
    sfr_pkg::t_res             load_res [NE];
    sfr_pkg::t_res             chain    [NE];
    sfr_pkg::t_res             r_out;
    logic                      r_out_valid;
    logic                      move;

    // APB access: always ready, writes land in the access phase.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = sfr_pkg::t_reg_idx'(paddr[sfr_pkg::ADDR_W-1:sfr_pkg::IDX_LSB]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_find_pat <= '0;
            r_find_len <= sfr_pkg::LEN_W'(1);
            r_repl_pat <= '0;
            r_repl_len <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                sfr_pkg::REG_FIND_PAT: r_find_pat <= pwdata;
                sfr_pkg::REG_FIND_LEN: r_find_len <= pwdata[sfr_pkg::LEN_W-1:0];
                sfr_pkg::REG_REPL_PAT: r_repl_pat <= pwdata;
                sfr_pkg::REG_REPL_LEN: r_repl_len <= pwdata[sfr_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back
    always_comb begin
        unique case (cfg_idx)
            sfr_pkg::REG_FIND_PAT: prdata = r_find_pat;
            sfr_pkg::REG_FIND_LEN: prdata = sfr_pkg::DATA_W'(r_find_len);
            sfr_pkg::REG_REPL_PAT: prdata = r_repl_pat;
            sfr_pkg::REG_REPL_LEN: prdata = sfr_pkg::DATA_W'(r_repl_len);
            default:               prdata = '0;
        endcase
    end

    assign flen = sfr_pkg::eff_find_len(r_find_len);
    assign rlen = sfr_pkg::eff_repl_len(r_repl_len);

    // Row of window cells. Each cell sees the incoming byte and its right neighbor.
    for (genvar i = 0; i < NW; i++) begin : g_win
        logic [BW-1:0] next_cand;

        if (i == NW - 1) begin : g_end
            assign next_cand = cand[i];
        end else begin : g_mid
            assign next_cand = cand[i+1];
        end

        assign cmp_en[i] = (sfr_pkg::CNT_W'(i) < flen);

        sfr_win_cell u_cell (
            .i_clk       (i_clk),
            .i_we        (accept),
            .i_take_in   (r_cnt == sfr_pkg::CNT_W'(i)),
            .i_shift     (shift_win),
            .i_in_byte   (i_in_byte),
            .i_pat_byte  (r_find_pat[BW*i +: BW]),
            .i_next_cand (next_cand),
            .o_cand      (cand[i]),
            .o_eq        (eq[i])
        );
    end

    // Window full check and match against the active part of the pattern.
    assign accept    = i_in_valid && o_in_ready;
    assign new_cnt   = r_cnt + sfr_pkg::CNT_W'(1);
    assign full      = (new_cnt == flen);
    assign hit       = full && (&(eq | ~cmp_en));
    assign shift_win = full && !hit;
    assign marker    = hit && i_in_last && (rlen == '0);

    // Window count: cleared on a match, at end of string and on a find-length write.
    always_comb begin
        n_cnt = r_cnt;
        if (cfg_wr && (cfg_idx == sfr_pkg::REG_FIND_LEN)) begin
            n_cnt = '0;
        end else if (accept) begin
            if (i_in_last || hit) begin
                n_cnt = '0;
            end else if (full) begin
                n_cnt = new_cnt - sfr_pkg::CNT_W'(1);
            end else begin
                n_cnt = new_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // Number of results this byte causes.
    always_comb begin
        if (hit) begin
            if (rlen == '0) begin
                num_res = i_in_last ? sfr_pkg::EMIT_W'(1) : '0;
            end else begin
                num_res = rlen;
            end
        end else if (i_in_last) begin
            num_res = sfr_pkg::EMIT_W'(new_cnt);
        end else begin
            num_res = full ? sfr_pkg::EMIT_W'(1) : '0;
        end
    end

    // Burst of results: replacement bytes or a bare end marker on a match, else a window prefix.
    always_comb begin
        for (int k = 0; k < NE; k++) begin
            load_res[k].valid    = (sfr_pkg::EMIT_W'(k) < num_res);
            load_res[k].has      = !marker;
            load_res[k].run_last = (sfr_pkg::EMIT_W'(k + 1) == num_res);
            load_res[k].str_end  = (sfr_pkg::EMIT_W'(k + 1) == num_res) && i_in_last;
            load_res[k].data     = '0;
            if (hit) begin
                if (!marker && (k < sfr_pkg::MAX_REPLACE_LEN)) begin
                    load_res[k].data = r_repl_pat[BW*k +: BW];
                end
            end else if (k < NW) begin
                load_res[k].data = cand[k];
            end
        end
    end

    // Row of emit cells; the head feeds the output register.
    for (genvar k = 0; k < NE; k++) begin : g_emit
        sfr_pkg::t_res next_res;

        if (k == NE - 1) begin : g_end
            assign next_res = '0;
        end else begin : g_mid
            assign next_res = chain[k+1];
        end

        sfr_emit_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_load     (accept),
            .i_shift    (move),
            .i_load_res (load_res[k]),
            .i_next_res (next_res),
            .o_res      (chain[k])
        );
    end

    // The head moves out when the output register is empty or being taken.
    assign move = chain[0].valid && (!r_out_valid || i_out_ready);

    // A byte is taken once the chain is empty after this cycle's move.
    assign o_in_ready = !chain[0].valid || (!chain[1].valid && move);

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out <= chain[0];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out.data;
    assign o_has_byte   = r_out.has;
    assign o_run_last   = r_out.run_last;
    assign o_string_end = r_out.str_end;

endmodule

// ===== design/sfr_checker.sv =====
// Port-level checker for the stream find-and-replace block, bound to the top level.
// Depends on stream_find_and_replace_top_assert.svh and sfr_pkg.
`include "stream_find_and_replace_top_assert.svh"

module sfr_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic [sfr_pkg::BYTE_W-1:0] o_out_byte,
    input logic                       o_has_byte,
    input logic                       o_run_last,
    input logic                       o_string_end,
    input logic                       pready
);

    // A stalled result transfer stays valid and keeps its byte, has flag and string end.
    `SFR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_byte) && $stable(o_has_byte) && $stable(o_string_end), "stalled result changed")

    // The end of a string is always the last result of its byte.
    `SFR_ASSERT_IMP(a_end_is_run_last, i_clk, i_rst_n, o_out_valid && o_string_end, o_run_last, "string end without run last")

    // A bare marker only closes a string and carries a zero byte.
    `SFR_ASSERT_IMP(a_bare_marker, i_clk, i_rst_n, o_out_valid && !o_has_byte, o_string_end && (o_out_byte == '0), "bad bare end marker")

    // The configuration port never inserts wait states.
    `SFR_ASSERT_ALWAYS(a_pready_high, i_clk, i_rst_n, pready, "pready dropped")

endmodule

bind stream_find_and_replace_top sfr_checker u_sfr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_out_byte   (o_out_byte),
    .o_has_byte   (o_has_byte),
    .o_run_last   (o_run_last),
    .o_string_end (o_string_end),
    .pready       (pready)
);
